// ----- rtl/cvd_pkg.sv -----
// Shared constants for the cosine vector distance block.
package cvd_pkg;
   localparam int DIST_W     = 19;
   localparam int FRAC_SHIFT = 17;
   localparam logic [DIST_W-1:0] TWO_Q16  = 19'd131072;
   localparam logic [DIST_W-1:0] FOUR_Q16 = 19'd262144;
endpackage

// ----- rtl/cvd_front.sv -----
// Front end: accept element pairs, accumulate the three sums, emit a job per vector.
module cvd_front #(
   parameter int MAX_DIM = 256,
   parameter int SQ_W    = 39,
   parameter int XY_W    = 40
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [31:0]            req_tdata,
   input  logic                   req_tlast,
   input  logic                   q_full,
   output logic                   push,
   output logic [SQ_W-1:0]        push_xx,
   output logic [SQ_W-1:0]        push_yy,
   output logic signed [XY_W-1:0] push_xy,
   output logic                   push_long
);
   localparam int CNT_W = $clog2(MAX_DIM + 1);

   logic [SQ_W-1:0]        sum_xx_ff, sum_xx_in;
   logic [SQ_W-1:0]        sum_yy_ff, sum_yy_in;
   logic signed [XY_W-1:0] sum_xy_ff, sum_xy_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   over_ff, over_in;
   logic signed [15:0]     x_elem, y_elem;
   logic signed [31:0]     pxx, pyy, pxy;
   logic                   accept, room;

   assign x_elem     = req_tdata[15:0];
   assign y_elem     = req_tdata[31:16];
   assign pxx        = x_elem * x_elem;
   assign pyy        = y_elem * y_elem;
   assign pxy        = x_elem * y_elem;
   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign room       = count_ff < CNT_W'(MAX_DIM);

   always_comb begin
      sum_xx_in = sum_xx_ff;
      sum_yy_in = sum_yy_ff;
      sum_xy_in = sum_xy_ff;
      count_in  = count_ff;
      over_in   = over_ff;
      if (room) begin
         sum_xx_in = sum_xx_ff + SQ_W'($unsigned(pxx));
         sum_yy_in = sum_yy_ff + SQ_W'($unsigned(pyy));
         sum_xy_in = sum_xy_ff + XY_W'(pxy);
         count_in  = count_ff + CNT_W'(1);
      end else begin
         over_in = 1'b1;
      end
   end

   assign push      = accept && req_tlast;
   assign push_xx   = sum_xx_in;
   assign push_yy   = sum_yy_in;
   assign push_xy   = sum_xy_in;
   assign push_long = over_in;

   always_ff @(posedge clock) begin
      if (reset || push) begin
         sum_xx_ff <= '0;
         sum_yy_ff <= '0;
         sum_xy_ff <= '0;
         count_ff  <= '0;
         over_ff   <= 1'b0;
      end else if (accept) begin
         sum_xx_ff <= sum_xx_in;
         sum_yy_ff <= sum_yy_in;
         sum_xy_ff <= sum_xy_in;
         count_ff  <= count_in;
         over_ff   <= over_in;
      end
   end
endmodule

// ----- rtl/cvd_queue.sv -----
// Two-entry job queue between front and back end.
module cvd_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);
   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ff, rd_ff;
   logic [1:0]       fill_ff;

   assign full      = fill_ff == 2'd2;
   assign not_empty = fill_ff != 2'd0;
   assign pop_data  = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= 1'b0;
         rd_ff   <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         if (push) begin
            wr_ff <= !wr_ff;
         end
         if (pop) begin
            rd_ff <= !rd_ff;
         end
         fill_ff <= fill_ff + 2'(push) - 2'(pop);
      end
   end
endmodule

// ----- rtl/cvd_back.sv -----
// Back end: serial multiply, digit-by-digit root and restoring divide per job.
module cvd_back #(
   parameter int SQ_W = 39,
   parameter int XY_W = 40
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          job_valid,
   input  logic [SQ_W-1:0]               job_xx,
   input  logic [SQ_W-1:0]               job_yy,
   input  logic signed [XY_W-1:0]        job_xy,
   input  logic                          job_long,
   output logic                          pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [cvd_pkg::DIST_W-1:0]    rsp_dist,
   output logic                          rsp_zero,
   output logic                          rsp_long
);
   localparam int P_W   = 2 * SQ_W;
   localparam int REM_W = SQ_W + 3;
   localparam int DV_W  = XY_W + cvd_pkg::FRAC_SHIFT;
   localparam int CNT_W = $clog2(DV_W + 1);
   localparam int DW    = cvd_pkg::DIST_W;

   typedef enum logic [2:0] {IDLE, MUL, SQRT, DIV, DONE} state_type;

   state_type          state_ff;
   logic [SQ_W-1:0]    a_ff, b_ff, root_ff;
   logic [P_W-1:0]     acc_ff;
   logic [REM_W-1:0]   rem_ff;
   logic [DV_W-1:0]    dvd_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               neg_ff, zero_ff, long_ff;
   logic [XY_W-1:0]    mag;
   logic [REM_W-1:0]   rem_sh, trial;
   logic [SQ_W:0]      div_r;
   logic [DW-1:0]      qc;
   logic [DW:0]        dsum;
   logic [DW-1:0]      dist_value;
   logic               last_step, out_free;

   assign pop       = (state_ff == IDLE) && job_valid;
   assign mag       = job_xy[XY_W-1] ? XY_W'(-job_xy) : XY_W'(job_xy);
   assign rem_sh    = {rem_ff[REM_W-3:0], acc_ff[P_W-1 -: 2]};
   assign trial     = {1'b0, root_ff, 2'b01};
   assign div_r     = {rem_ff[SQ_W-1:0], dvd_ff[DV_W-1]};
   assign last_step = cnt_ff == CNT_W'(1);
   assign out_free  = !rsp_tvalid || rsp_tready;

   always_comb begin
      qc = (dvd_ff > DV_W'(cvd_pkg::FOUR_Q16)) ? cvd_pkg::FOUR_Q16 : dvd_ff[DW-1:0];
      if (neg_ff) begin
         dsum = {1'b0, cvd_pkg::TWO_Q16} + {1'b0, qc};
         dist_value = (dsum > {1'b0, cvd_pkg::FOUR_Q16}) ? cvd_pkg::FOUR_Q16 : dsum[DW-1:0];
      end else begin
         dsum = {1'b0, cvd_pkg::TWO_Q16} - {1'b0, qc};
         dist_value = (qc > cvd_pkg::TWO_Q16) ? '0 : dsum[DW-1:0];
      end
      if (zero_ff) begin
         dist_value = cvd_pkg::TWO_Q16;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= IDLE;
         rsp_tvalid <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready && (state_ff != DONE)) begin
            rsp_tvalid <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (job_valid) begin
                  a_ff    <= job_xx;
                  b_ff    <= job_yy;
                  acc_ff  <= '0;
                  rem_ff  <= '0;
                  root_ff <= '0;
                  cnt_ff  <= CNT_W'(SQ_W);
                  neg_ff  <= job_xy[XY_W-1];
                  dvd_ff  <= {mag, {cvd_pkg::FRAC_SHIFT{1'b0}}};
                  long_ff <= job_long;
                  zero_ff <= (job_xx == '0) || (job_yy == '0);
                  state_ff <= ((job_xx == '0) || (job_yy == '0)) ? DONE : MUL;
               end
            end
            MUL: begin
               acc_ff <= {acc_ff[P_W-2:0], 1'b0} + (b_ff[SQ_W-1] ? P_W'(a_ff) : '0);
               b_ff   <= {b_ff[SQ_W-2:0], 1'b0};
               if (last_step) begin
                  cnt_ff   <= CNT_W'(SQ_W);
                  state_ff <= SQRT;
               end else begin
                  cnt_ff <= cnt_ff - CNT_W'(1);
               end
            end
            SQRT: begin
               acc_ff <= {acc_ff[P_W-3:0], 2'b00};
               if (rem_sh >= trial) begin
                  root_ff <= {root_ff[SQ_W-2:0], 1'b1};
               end else begin
                  root_ff <= {root_ff[SQ_W-2:0], 1'b0};
               end
               // the divide starts from an empty remainder
               if (last_step) begin
                  rem_ff   <= '0;
                  cnt_ff   <= CNT_W'(DV_W);
                  state_ff <= DIV;
               end else begin
                  rem_ff <= (rem_sh >= trial) ? rem_sh - trial : rem_sh;
                  cnt_ff <= cnt_ff - CNT_W'(1);
               end
            end
            DIV: begin
               // hold the remainder below the root; quotient bits fill dvd from the bottom
               if (div_r >= {1'b0, root_ff}) begin
                  rem_ff <= REM_W'(div_r - {1'b0, root_ff});
                  dvd_ff <= {dvd_ff[DV_W-2:0], 1'b1};
               end else begin
                  rem_ff <= REM_W'(div_r);
                  dvd_ff <= {dvd_ff[DV_W-2:0], 1'b0};
               end
               if (last_step) begin
                  state_ff <= DONE;
               end else begin
                  cnt_ff <= cnt_ff - CNT_W'(1);
               end
            end
            DONE: begin
               if (out_free) begin
                  rsp_tvalid <= 1'b1;
                  rsp_dist   <= dist_value;
                  rsp_zero   <= zero_ff;
                  rsp_long   <= long_ff;
                  state_ff   <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end
endmodule

// ----- rtl/cosine_vector_distance.sv -----
// Top level of the streaming cosine (angular) distance unit.
//
// Element pairs (x, y) stream in at one transaction per clock while req_tready
// is high; the front end squares and multiplies them and keeps the sums x.x,
// y.y and x.y exactly. Pairs after the first MAX_DIM of a vector are dropped
// and reported through too_long. On the transaction marked with tlast the
// three sums go into a two-entry queue and are cleared, so the next vector
// streams in at once. The back end takes one job at a time and works it out
// serially: a shift-add multiply of x.x by y.y, a two-bits-per-cycle floor
// square root and a restoring divide of |x.y| * 2^17 by the root, then clamps
// 2 - 2*cos to 0.0..4.0 in Q3.16. When either norm is zero it skips these
// steps and returns 2.0 with zero_norm set. A vector whose pairs take at least
// as long to stream in as the back end needs per job streams without a stall
// while rsp_tready stays high; shorter ones back-pressure req_tready once both
// queue entries are taken. Results come out in vector order, each after the
// jobs queued ahead of it.
module cosine_vector_distance #(
   parameter int MAX_DIM = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] x_elem, [31:16] y_elem
   input  logic        req_tlast,   // last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [18:0] distance, [23:19] zero
   output logic [1:0]  rsp_tuser    // [0] zero_norm, [1] too_long
);
   localparam int SQ_W = 31 + $clog2(MAX_DIM);
   localparam int XY_W = 32 + $clog2(MAX_DIM);
   localparam int JOB_W = 2 * SQ_W + XY_W + 1;

   logic                   q_full, q_push, q_pop, q_valid;
   logic [SQ_W-1:0]        push_xx, push_yy;
   logic signed [XY_W-1:0] push_xy;
   logic                   push_long;
   logic [JOB_W-1:0]       q_out;
   logic [cvd_pkg::DIST_W-1:0] rsp_distance;

   cvd_front #(.MAX_DIM(MAX_DIM), .SQ_W(SQ_W), .XY_W(XY_W)) u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tlast,
      .q_full, .push(q_push), .push_xx, .push_yy, .push_xy, .push_long
   );

   // Decouple accumulation from the serial back end.
   cvd_queue #(.WIDTH(JOB_W)) u_queue (
      .clock, .reset, .push(q_push),
      .push_data({push_long, push_xy, push_yy, push_xx}),
      .full(q_full), .pop(q_pop), .not_empty(q_valid), .pop_data(q_out)
   );

   cvd_back #(.SQ_W(SQ_W), .XY_W(XY_W)) u_back (
      .clock, .reset, .job_valid(q_valid),
      .job_xx(q_out[SQ_W-1:0]),
      .job_yy(q_out[2*SQ_W-1:SQ_W]),
      .job_xy(q_out[2*SQ_W+XY_W-1:2*SQ_W]),
      .job_long(q_out[JOB_W-1]),
      .pop(q_pop), .rsp_tvalid, .rsp_tready,
      .rsp_dist(rsp_distance), .rsp_zero(rsp_tuser[0]), .rsp_long(rsp_tuser[1])
   );

   assign rsp_tdata = {5'd0, rsp_distance};
endmodule

// ----- rtl/cvd_checker.sv -----
// Port-level assertions for the cosine vector distance unit, with bind.
module cvd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[18:0] <= cvd_pkg::FOUR_Q16)
      else $error("distance above 4.0");

   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[18:0] == cvd_pkg::TWO_Q16)
      else $error("zero norm without 2.0");

   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");
endmodule

bind cosine_vector_distance cvd_checker u_cvd_checker (
   .clock, .reset, .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
);
